[rtl/core/alu8_pkg.sv]
// ----------------------------------------------------------------------------
// alu8_pkg: shared types and codes for the 8-bit CPU ALU
// Command codes, flag layout, DAA constants and the request and response
// bundles passed between the top level and the datapath.
// ----------------------------------------------------------------------------
package alu8_pkg;

  // Command codes
  localparam logic [4:0] OP_ADD   = 5'd0;
  localparam logic [4:0] OP_ADC   = 5'd1;
  localparam logic [4:0] OP_SUB   = 5'd2;
  localparam logic [4:0] OP_SBC   = 5'd3;
  localparam logic [4:0] OP_AND   = 5'd4;
  localparam logic [4:0] OP_XOR   = 5'd5;
  localparam logic [4:0] OP_OR    = 5'd6;
  localparam logic [4:0] OP_CP    = 5'd7;
  localparam logic [4:0] OP_INC8  = 5'd8;
  localparam logic [4:0] OP_DEC8  = 5'd9;
  localparam logic [4:0] OP_INC16 = 5'd10;
  localparam logic [4:0] OP_DEC16 = 5'd11;
  localparam logic [4:0] OP_ADDHL = 5'd12;
  localparam logic [4:0] OP_ADDSP = 5'd13;
  localparam logic [4:0] OP_DAA   = 5'd14;
  localparam logic [4:0] OP_CPL   = 5'd15;
  localparam logic [4:0] OP_SCF   = 5'd16;
  localparam logic [4:0] OP_CCF   = 5'd17;

  // Flag bit positions in the 4-bit flag word
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  // Decimal adjust constants
  localparam logic [3:0] DAA_LOW_MAX  = 4'h9;
  localparam logic [7:0] DAA_HIGH_MAX = 8'h99;
  localparam logic [7:0] DAA_ADJ_LOW  = 8'h06;
  localparam logic [7:0] DAA_ADJ_HIGH = 8'h60;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [4:0]  command;
    logic [7:0]  acc;
    flags_t      flags;
    logic [15:0] hl;
    logic [15:0] sp;
    logic [7:0]  opb;
    logic [15:0] opw;
  } req_t;

  typedef struct packed {
    logic [7:0]  acc;
    flags_t      flags;
    logic [15:0] hl;
    logic [15:0] sp;
    logic [7:0]  byte_result;
    logic [15:0] word_result;
  } rsp_t;

endpackage

[rtl/core/eight_bit_cpu_alu_with_flags_top.sv]
// ----------------------------------------------------------------------------
// eight_bit_cpu_alu_with_flags_top: 8-bit CPU ALU with flags and DAA
// Registered single-pass ALU: input register, datapath, result register.
//
// Usage:
//   Command channel: drive command and operands with start high; the item is
//   taken at the rising edge where start is high and busy is low. busy never
//   rises, so one item can be taken in every cycle.
//   Result channel: done pulses for one cycle with acc_out, flags_out,
//   hl_out, sp_out, byte_result and word_result valid in that cycle.
//   An accepted item passes the input register, then the result register;
//   throughput is 1 item per cycle, as the datapath between the two
//   registers is combinational.
//   The receiver cannot stall: each result is shown for exactly one cycle
//   and must be captured then.
//   Reset (rst, synchronous, active high) drops any item in flight; done is
//   low on the cycle after reset.
// ----------------------------------------------------------------------------
module eight_bit_cpu_alu_with_flags_top
  import alu8_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  command,
  input  logic [7:0]  acc_in,
  input  logic [3:0]  flags_in,
  input  logic [15:0] hl_in,
  input  logic [15:0] sp_in,
  input  logic [7:0]  operand_byte,
  input  logic [15:0] operand_word,
  output logic        done,
  output logic [7:0]  acc_out,
  output logic [3:0]  flags_out,
  output logic [15:0] hl_out,
  output logic [15:0] sp_out,
  output logic [7:0]  byte_result,
  output logic [15:0] word_result
);

  logic s1_valid;
  req_t s1_req;
  rsp_t s1_rsp;
  rsp_t out_q;

  // Always ready for a new item
  assign busy = 1'b0;

  // Capture the item into the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start & ~busy;
    end
    if (start & ~busy) begin
      s1_req <= '{command: command, acc: acc_in, flags: flags_t'(flags_in), hl: hl_in,
                  sp: sp_in, opb: operand_byte, opw: operand_word};
    end
  end

  alu8_datapath u_datapath (
    .req (s1_req),
    .rsp (s1_rsp)
  );

  // Load the result register and raise the strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
    if (s1_valid) begin
      out_q <= s1_rsp;
    end
  end

  assign acc_out     = out_q.acc;
  assign flags_out   = out_q.flags;
  assign hl_out      = out_q.hl;
  assign sp_out      = out_q.sp;
  assign byte_result = out_q.byte_result;
  assign word_result = out_q.word_result;

  // Every item in the input register yields a result next cycle
  a_stage_to_done: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> done)
    else $error("item in input register produced no result");

  // A result only follows an accepted item
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 2))
    else $error("result strobe without an accepted item");

  // HL changes only on add hl
  a_hl_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_req.command != OP_ADDHL) |=> (hl_out == $past(s1_req.hl)))
    else $error("HL changed by a command other than add hl");

  // Word result is zero except for 16-bit increment and decrement
  a_word_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_req.command != OP_INC16 && s1_req.command != OP_DEC16)
      |=> (word_result == 16'h0000))
    else $error("word result nonzero for a non-16-bit command");

endmodule

[rtl/core/alu8_datapath.sv]
// ----------------------------------------------------------------------------
// alu8_datapath: single-pass arithmetic and flag logic
// Computes the new accumulator, flags, HL, SP and the byte and word results
// for one registered command.
// ----------------------------------------------------------------------------
module alu8_datapath
  import alu8_pkg::*;
(
  input  req_t req,
  output rsp_t rsp
);

  logic       c_add;
  logic       c_sub;
  logic [8:0] add_sum;
  logic [4:0] add_half;
  logic [8:0] sub_diff;
  logic [4:0] sub_half;
  logic [7:0] and_val;
  logic [7:0] xor_val;
  logic [7:0] or_val;
  logic [7:0] inc_val;
  logic [7:0] dec_val;
  logic [16:0] hl_sum;
  logic [12:0] hl_half;
  logic [15:0] sp_sum;
  logic [4:0] sp_half;
  logic [8:0] sp_low;
  logic       daa_lo;
  logic       daa_hi;
  logic [7:0] daa_adj_sub;
  logic [7:0] daa_adj_add;
  logic [7:0] daa_val;
  logic       daa_c;

  // Carry-in for adc and sbc only
  assign c_add = (req.command == OP_ADC) & req.flags.c;
  assign c_sub = (req.command == OP_SBC) & req.flags.c;

  // 8-bit add with half carry
  assign add_sum  = {1'b0, req.acc} + {1'b0, req.opb} + {8'b0, c_add};
  assign add_half = {1'b0, req.acc[3:0]} + {1'b0, req.opb[3:0]} + {4'b0, c_add};

  // 8-bit subtract; the top bit of each difference is the borrow
  assign sub_diff = {1'b0, req.acc} - {1'b0, req.opb} - {8'b0, c_sub};
  assign sub_half = {1'b0, req.acc[3:0]} - {1'b0, req.opb[3:0]} - {4'b0, c_sub};

  // Logic operations
  assign and_val = req.acc & req.opb;
  assign xor_val = req.acc ^ req.opb;
  assign or_val  = req.acc | req.opb;

  // Byte increment and decrement
  assign inc_val = req.opb + 8'd1;
  assign dec_val = req.opb - 8'd1;

  // 16-bit add to HL, half carry out of bit 11
  assign hl_sum  = {1'b0, req.hl} + {1'b0, req.opw};
  assign hl_half = {1'b0, req.hl[11:0]} + {1'b0, req.opw[11:0]};

  // SP plus signed offset, flags from the unsigned low-byte add
  assign sp_sum  = req.sp + {{8{req.opb[7]}}, req.opb};
  assign sp_half = {1'b0, req.sp[3:0]} + {1'b0, req.opb[3:0]};
  assign sp_low  = {1'b0, req.sp[7:0]} + {1'b0, req.opb};

  // Decimal adjust, both tests on the original accumulator
  assign daa_lo      = req.flags.h | (req.acc[3:0] > DAA_LOW_MAX);
  assign daa_hi      = req.flags.c | (req.acc > DAA_HIGH_MAX);
  assign daa_adj_sub = (req.flags.h ? DAA_ADJ_LOW : 8'h00)
                     | (req.flags.c ? DAA_ADJ_HIGH : 8'h00);
  assign daa_adj_add = (daa_lo ? DAA_ADJ_LOW : 8'h00) | (daa_hi ? DAA_ADJ_HIGH : 8'h00);
  assign daa_val     = req.flags.n ? (req.acc - daa_adj_sub) : (req.acc + daa_adj_add);
  assign daa_c       = req.flags.n ? req.flags.c : daa_hi;

  // Select results by command; unknown codes pass state through
  always_comb begin
    rsp.acc         = req.acc;
    rsp.flags       = req.flags;
    rsp.hl          = req.hl;
    rsp.sp          = req.sp;
    rsp.byte_result = 8'h00;
    rsp.word_result = 16'h0000;
    case (req.command)
      OP_ADD, OP_ADC: begin
        rsp.acc   = add_sum[7:0];
        rsp.flags = '{z: (add_sum[7:0] == 8'h00), n: 1'b0, h: add_half[4], c: add_sum[8]};
      end
      OP_SUB, OP_SBC: begin
        rsp.acc   = sub_diff[7:0];
        rsp.flags = '{z: (sub_diff[7:0] == 8'h00), n: 1'b1, h: sub_half[4], c: sub_diff[8]};
      end
      OP_CP: begin
        rsp.flags = '{z: (sub_diff[7:0] == 8'h00), n: 1'b1, h: sub_half[4], c: sub_diff[8]};
      end
      OP_AND: begin
        rsp.acc   = and_val;
        rsp.flags = '{z: (and_val == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      OP_XOR: begin
        rsp.acc   = xor_val;
        rsp.flags = '{z: (xor_val == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_OR: begin
        rsp.acc   = or_val;
        rsp.flags = '{z: (or_val == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_INC8: begin
        rsp.byte_result = inc_val;
        rsp.flags = '{z: (inc_val == 8'h00), n: 1'b0, h: (req.opb[3:0] == 4'hF),
                      c: req.flags.c};
      end
      OP_DEC8: begin
        rsp.byte_result = dec_val;
        rsp.flags = '{z: (dec_val == 8'h00), n: 1'b1, h: (req.opb[3:0] == 4'h0),
                      c: req.flags.c};
      end
      OP_INC16: begin
        rsp.word_result = req.opw + 16'd1;
      end
      OP_DEC16: begin
        rsp.word_result = req.opw - 16'd1;
      end
      OP_ADDHL: begin
        rsp.hl    = hl_sum[15:0];
        rsp.flags = '{z: req.flags.z, n: 1'b0, h: hl_half[12], c: hl_sum[16]};
      end
      OP_ADDSP: begin
        rsp.sp    = sp_sum;
        rsp.flags = '{z: 1'b0, n: 1'b0, h: sp_half[4], c: sp_low[8]};
      end
      OP_DAA: begin
        rsp.acc   = daa_val;
        rsp.flags = '{z: (daa_val == 8'h00), n: req.flags.n, h: 1'b0, c: daa_c};
      end
      OP_CPL: begin
        rsp.acc   = ~req.acc;
        rsp.flags = '{z: req.flags.z, n: 1'b1, h: 1'b1, c: req.flags.c};
      end
      OP_SCF: begin
        rsp.flags = '{z: req.flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      OP_CCF: begin
        rsp.flags = '{z: req.flags.z, n: 1'b0, h: 1'b0, c: ~req.flags.c};
      end
      default: begin
        rsp.acc = req.acc;
      end
    endcase
  end

endmodule

[test/tb_eight_bit_cpu_alu_with_flags_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eight_bit_cpu_alu_with_flags_top: self-checking bench for the 8-bit ALU
// Drives directed corner items, then random items, through the start/busy
// command port with random sender gaps. Each result strobed by done is
// compared field by field with a prediction made when the item was taken.
// ----------------------------------------------------------------------------
module tb_eight_bit_cpu_alu_with_flags_top
  import alu8_pkg::*;
();

  localparam int ITEM_COUNT  = 1150;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        done;
  logic [7:0]  acc_out;
  logic [3:0]  flags_out;
  logic [15:0] hl_out;
  logic [15:0] sp_out;
  logic [7:0]  byte_result;
  logic [15:0] word_result;

  req_t drv_item = '0;
  req_t cmd_pending_q[$];
  rsp_t alu_expected_q[$];

  bit item_taken = 1'b0;
  int n_taken = 0;
  int item_total = 0;
  int gap_pct = 0;
  int idle_cycles = 0;
  int fail_count = 0;

  eight_bit_cpu_alu_with_flags_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(drv_item.command),
    .acc_in(drv_item.acc),
    .flags_in(drv_item.flags),
    .hl_in(drv_item.hl),
    .sp_in(drv_item.sp),
    .operand_byte(drv_item.opb),
    .operand_word(drv_item.opw),
    .done(done),
    .acc_out(acc_out),
    .flags_out(flags_out),
    .hl_out(hl_out),
    .sp_out(sp_out),
    .byte_result(byte_result),
    .word_result(word_result)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Compute the ALU outputs for one command item
  function automatic rsp_t alu_predict(req_t rq);
    rsp_t       rs;
    logic       cy;
    logic [8:0] wide8;
    logic [4:0] nib;
    logic [16:0] wide16;
    logic [12:0] wide12;
    logic [7:0] adj;
    rs.acc = rq.acc;
    rs.flags = rq.flags;
    rs.hl = rq.hl;
    rs.sp = rq.sp;
    rs.byte_result = 8'h00;
    rs.word_result = 16'h0000;
    cy = (rq.command == OP_ADC || rq.command == OP_SBC) ? rq.flags.c : 1'b0;
    case (rq.command)
      OP_ADD, OP_ADC: begin
        wide8 = {1'b0, rq.acc} + {1'b0, rq.opb} + {8'h00, cy};
        nib = {1'b0, rq.acc[3:0]} + {1'b0, rq.opb[3:0]} + {4'h0, cy};
        rs.acc = wide8[7:0];
        rs.flags = '{z: (wide8[7:0] == 8'h00), n: 1'b0, h: nib[4], c: wide8[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        // bit 8 / bit 4 of the extended difference is the borrow
        wide8 = {1'b0, rq.acc} - {1'b0, rq.opb} - {8'h00, cy};
        nib = {1'b0, rq.acc[3:0]} - {1'b0, rq.opb[3:0]} - {4'h0, cy};
        if (rq.command != OP_CP) rs.acc = wide8[7:0];
        rs.flags = '{z: (wide8[7:0] == 8'h00), n: 1'b1, h: nib[4], c: wide8[8]};
      end
      OP_AND: begin
        rs.acc = rq.acc & rq.opb;
        rs.flags = '{z: (rs.acc == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      OP_XOR: begin
        rs.acc = rq.acc ^ rq.opb;
        rs.flags = '{z: (rs.acc == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_OR: begin
        rs.acc = rq.acc | rq.opb;
        rs.flags = '{z: (rs.acc == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_INC8: begin
        rs.byte_result = rq.opb + 8'h01;
        rs.flags = '{z: (rs.byte_result == 8'h00), n: 1'b0,
                     h: (rq.opb[3:0] == 4'hF), c: rq.flags.c};
      end
      OP_DEC8: begin
        rs.byte_result = rq.opb - 8'h01;
        rs.flags = '{z: (rs.byte_result == 8'h00), n: 1'b1,
                     h: (rq.opb[3:0] == 4'h0), c: rq.flags.c};
      end
      OP_INC16: rs.word_result = rq.opw + 16'h0001;
      OP_DEC16: rs.word_result = rq.opw - 16'h0001;
      OP_ADDHL: begin
        wide16 = {1'b0, rq.hl} + {1'b0, rq.opw};
        wide12 = {1'b0, rq.hl[11:0]} + {1'b0, rq.opw[11:0]};
        rs.hl = wide16[15:0];
        rs.flags = '{z: rq.flags.z, n: 1'b0, h: wide12[12], c: wide16[16]};
      end
      OP_ADDSP: begin
        // sign-extended offset; flags from the unsigned low-byte add
        rs.sp = rq.sp + {{8{rq.opb[7]}}, rq.opb};
        wide8 = {1'b0, rq.sp[7:0]} + {1'b0, rq.opb};
        nib = {1'b0, rq.sp[3:0]} + {1'b0, rq.opb[3:0]};
        rs.flags = '{z: 1'b0, n: 1'b0, h: nib[4], c: wide8[8]};
      end
      OP_DAA: begin
        adj = 8'h00;
        rs.flags.c = rq.flags.c;
        if (rq.flags.n) begin
          if (rq.flags.h) adj = adj + DAA_ADJ_LOW;
          if (rq.flags.c) adj = adj + DAA_ADJ_HIGH;
          rs.acc = rq.acc - adj;
        end else begin
          if (rq.flags.h || rq.acc[3:0] > DAA_LOW_MAX) adj = adj + DAA_ADJ_LOW;
          if (rq.flags.c || rq.acc > DAA_HIGH_MAX) begin
            adj = adj + DAA_ADJ_HIGH;
            rs.flags.c = 1'b1;
          end
          rs.acc = rq.acc + adj;
        end
        rs.flags.z = (rs.acc == 8'h00);
        rs.flags.h = 1'b0;
      end
      OP_CPL: begin
        rs.acc = ~rq.acc;
        rs.flags.n = 1'b1;
        rs.flags.h = 1'b1;
      end
      OP_SCF: rs.flags = '{z: rq.flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
      OP_CCF: rs.flags = '{z: rq.flags.z, n: 1'b0, h: 1'b0, c: ~rq.flags.c};
      default: ;
    endcase
    return rs;
  endfunction

  // Operand values biased toward the extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random item; most commands are defined, a few fall in the unused range
  function automatic req_t random_item();
    req_t rq;
    if ($urandom_range(15) == 0) rq.command = 5'($urandom_range(31, 18));
    else rq.command = 5'($urandom_range(17));
    rq.acc = pick_byte();
    rq.flags = 4'($urandom);
    rq.hl = pick_word();
    rq.sp = pick_word();
    rq.opb = pick_byte();
    rq.opw = pick_word();
    return rq;
  endfunction

  task automatic add_item(logic [4:0] cmd, logic [7:0] a, logic [3:0] f,
                          logic [15:0] hl, logic [15:0] sp, logic [7:0] b,
                          logic [15:0] w);
    cmd_pending_q.push_back('{command: cmd, acc: a, flags: f, hl: hl, sp: sp,
                              opb: b, opw: w});
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  // Driver: hold the item until taken, then load the next one or idle
  always @(negedge clk) begin
    if (!rst && (!start || item_taken)) begin
      if (n_taken < item_total / 3) gap_pct = 24;
      else if (n_taken < 2 * item_total / 3) gap_pct = 85;
      else gap_pct = 0;
      if (cmd_pending_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        drv_item <= cmd_pending_q.pop_front();
        start <= 1'b1;
      end else begin
        drv_item <= random_item();
        start <= 1'b0;
      end
    end
  end

  // Monitor: check results, record taken items, watch for a stall
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      item_taken = start && !busy;
      if (done) begin
        if (alu_expected_q.size() == 0) begin
          $error("result strobed with no item outstanding");
          fail_count++;
        end else begin
          want = alu_expected_q.pop_front();
          check_field("acc_out", 16'(want.acc), 16'(acc_out));
          check_field("flags_out", 16'(want.flags), 16'(flags_out));
          check_field("hl_out", want.hl, hl_out);
          check_field("sp_out", want.sp, sp_out);
          check_field("byte_result", 16'(want.byte_result), 16'(byte_result));
          check_field("word_result", want.word_result, word_result);
        end
      end
      if (item_taken) begin
        alu_expected_q.push_back(alu_predict(drv_item));
        n_taken++;
      end
      idle_cycles = (item_taken || done) ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    // arithmetic carries and borrows
    add_item(OP_ADD, 8'hFF, 4'h0, 16'h0000, 16'hFFFF, 8'h01, 16'hFFFF);
    add_item(OP_ADD, 8'h0F, 4'hF, 16'hFFFF, 16'h0000, 8'h01, 16'h0000);
    add_item(OP_ADC, 8'h0E, 4'h1, 16'h1234, 16'h4321, 8'h01, 16'h5555);
    add_item(OP_ADC, 8'hFF, 4'h1, 16'hAAAA, 16'h5555, 8'h00, 16'hFFFF);
    add_item(OP_SUB, 8'h10, 4'h0, 16'h0000, 16'h0000, 8'h01, 16'h0000);
    add_item(OP_SUB, 8'h00, 4'hF, 16'hFFFF, 16'hFFFF, 8'h01, 16'hFFFF);
    add_item(OP_SBC, 8'h00, 4'h1, 16'h0000, 16'h0000, 8'hFF, 16'h0000);
    // logic ops and compare
    add_item(OP_AND, 8'hF0, 4'h1, 16'h0000, 16'h0000, 8'h0F, 16'h0000);
    add_item(OP_XOR, 8'hFF, 4'hF, 16'h0000, 16'h0000, 8'hFF, 16'h0000);
    add_item(OP_OR,  8'h00, 4'h7, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    add_item(OP_CP,  8'h42, 4'h0, 16'h0000, 16'h0000, 8'h42, 16'h0000);
    // byte and word increment/decrement wrap
    add_item(OP_INC8,  8'h55, 4'h1, 16'h0000, 16'h0000, 8'hFF, 16'h0000);
    add_item(OP_INC8,  8'h55, 4'h0, 16'h0000, 16'h0000, 8'h0F, 16'h0000);
    add_item(OP_DEC8,  8'h55, 4'h0, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    add_item(OP_DEC8,  8'h55, 4'h9, 16'h0000, 16'h0000, 8'h01, 16'h0000);
    add_item(OP_INC16, 8'h00, 4'hA, 16'h0000, 16'h0000, 8'h00, 16'hFFFF);
    add_item(OP_DEC16, 8'h00, 4'h5, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    // 16-bit adds, including a negative stack offset
    add_item(OP_ADDHL, 8'h00, 4'h8, 16'h0FFF, 16'h0000, 8'h00, 16'h0001);
    add_item(OP_ADDHL, 8'h00, 4'h0, 16'hFFFF, 16'h0000, 8'h00, 16'hFFFF);
    add_item(OP_ADDSP, 8'h00, 4'hF, 16'h00FF, 16'h00FF, 8'hFF, 16'h0000);
    add_item(OP_ADDSP, 8'h00, 4'h0, 16'h0000, 16'hFFF8, 8'h80, 16'h0000);
    // decimal adjust after add and after subtract
    add_item(OP_DAA, 8'h9A, 4'h0, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    add_item(OP_DAA, 8'h00, 4'h2, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    add_item(OP_DAA, 8'h66, 4'h7, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    // flag ops and unused commands
    add_item(OP_CPL, 8'h5A, 4'h9, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    add_item(OP_SCF, 8'h00, 4'h6, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    add_item(OP_CCF, 8'h00, 4'hF, 16'h0000, 16'h0000, 8'h00, 16'h0000);
    add_item(5'd31,  8'hFF, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    while (cmd_pending_q.size() < ITEM_COUNT) cmd_pending_q.push_back(random_item());
    item_total = cmd_pending_q.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // drain: everything sent, every result back
    while (cmd_pending_q.size() != 0 || start || alu_expected_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/alu8_pkg.sv
rtl/core/alu8_datapath.sv
rtl/core/eight_bit_cpu_alu_with_flags_top.sv
test/tb_eight_bit_cpu_alu_with_flags_top.sv
